// ===== src/amseq_pkg.sv =====
// amseq_pkg: request and response types and mode codes of the addressing-mode sequencer
// no dependencies; used by cpu_addressing_mode_sequencer
package amseq_pkg;

   localparam logic [3:0] MODE_ACC  = 4'd0;
   localparam logic [3:0] MODE_IMPL = 4'd1;
   localparam logic [3:0] MODE_IMM  = 4'd2;
   localparam logic [3:0] MODE_REL  = 4'd3;
   localparam logic [3:0] MODE_ZP   = 4'd4;
   localparam logic [3:0] MODE_ZPX  = 4'd5;
   localparam logic [3:0] MODE_ZPY  = 4'd6;
   localparam logic [3:0] MODE_ABS  = 4'd7;
   localparam logic [3:0] MODE_ABSX = 4'd8;
   localparam logic [3:0] MODE_ABSY = 4'd9;
   localparam logic [3:0] MODE_INDX = 4'd10;
   localparam logic [3:0] MODE_INDY = 4'd11;
   localparam logic [3:0] MODE_IND  = 4'd12;

   localparam logic [15:0] LOW_BYTE_MASK  = 16'h00FF;
   localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;

   typedef struct packed {
      logic [3:0]  mode;
      logic [2:0]  cycle_index;
      logic [15:0] program_counter;
      logic [7:0]  index_x;
      logic [7:0]  index_y;
      logic [7:0]  read_data;
   } req_type;

   typedef struct packed {
      logic        read_enable;
      logic [15:0] read_address;
      logic [15:0] next_pc;
      logic [15:0] effective_address;
      logic        done_res;
   } rsp_type;

endpackage

// ===== src/cpu_addressing_mode_sequencer.sv =====
// cpu_addressing_mode_sequencer: 6502 effective-address sequencer, one cpu cycle per request
// depends on amseq_pkg for the request/response structs and mode codes

// Each request stands for one cpu clock cycle of an addressing sequence and
// gives exactly one response. A request is captured in an input register,
// worked out by one pass of short logic against the decoded address, pointer
// and page-cross state, and lands in the response register when it advances
// out of the input register, which a held response can delay. A new
// request is taken every cycle while responses are drained; req_stall rises
// only when a request already waits in the input register and the response
// register is held by rsp_stall.
module cpu_addressing_mode_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  amseq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output amseq_pkg::rsp_type rsp_data
);

   logic               s1_valid_ff;
   logic               s1_valid_in;
   amseq_pkg::req_type s1_req_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   amseq_pkg::rsp_type out_rsp_ff;
   amseq_pkg::rsp_type out_rsp_in;
   logic [15:0]        decoded_ff;
   logic [15:0]        decoded_in;
   logic [15:0]        pointer_ff;
   logic [15:0]        pointer_in;
   logic               crossed_ff;
   logic               crossed_in;
   logic               advance;
   logic               take_req;

   logic [15:0] pc;
   logic [15:0] pc_inc;
   logic [15:0] data16;
   logic [15:0] hi_merge;
   logic [7:0]  idx;
   logic [15:0] idx_sum;
   logic [15:0] cross_base;
   logic [2:0]  cyc;
   logic [3:0]  mode;

   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

   assign mode     = s1_req_ff.mode;
   assign cyc      = s1_req_ff.cycle_index;
   assign pc       = s1_req_ff.program_counter;
   assign pc_inc   = pc + 16'd1;
   assign data16   = {8'd0, s1_req_ff.read_data};
   assign hi_merge = (decoded_ff & amseq_pkg::LOW_BYTE_MASK) | {s1_req_ff.read_data, 8'd0};
   assign idx      = (mode == amseq_pkg::MODE_ZPY || mode == amseq_pkg::MODE_ABSY ||
                      mode == amseq_pkg::MODE_INDY)
                     ? s1_req_ff.index_y : s1_req_ff.index_x;

   // absolute indexed adds to the freshly merged address, indirect-indexed to the held one
   assign cross_base = (mode == amseq_pkg::MODE_INDY) ? decoded_ff
                       : ((decoded_ff & amseq_pkg::LOW_BYTE_MASK) |
                          {s1_req_ff.read_data, 8'd0});
   assign idx_sum    = cross_base + {8'd0, idx};

   always_comb begin
      decoded_in = decoded_ff;
      pointer_in = pointer_ff;
      crossed_in = crossed_ff;
      out_rsp_in = '0;
      out_rsp_in.next_pc = pc;
      case (mode)
         amseq_pkg::MODE_IMM, amseq_pkg::MODE_REL: begin
            decoded_in = pc;
            out_rsp_in.next_pc = pc_inc;
            out_rsp_in.done_res = 1'b1;
         end
         amseq_pkg::MODE_ZP: begin
            if (cyc == 3'd0) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pc;
               out_rsp_in.next_pc = pc_inc;
               decoded_in = data16;
            end
            out_rsp_in.done_res = (cyc == 3'd1);
         end
         amseq_pkg::MODE_ZPX, amseq_pkg::MODE_ZPY: begin
            if (cyc == 3'd0) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pc;
               out_rsp_in.next_pc = pc_inc;
               decoded_in = data16;
            end else if (cyc == 3'd1) begin
               decoded_in = (decoded_ff + {8'd0, idx}) & amseq_pkg::LOW_BYTE_MASK;
            end
            out_rsp_in.done_res = (cyc == 3'd2);
         end
         amseq_pkg::MODE_ABS: begin
            if (cyc == 3'd0 || cyc == 3'd1) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pc;
               out_rsp_in.next_pc = pc_inc;
               decoded_in = (cyc == 3'd0) ? data16 : hi_merge;
            end
            out_rsp_in.done_res = (cyc == 3'd2);
         end
         amseq_pkg::MODE_ABSX, amseq_pkg::MODE_ABSY: begin
            if (cyc == 3'd0) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pc;
               out_rsp_in.next_pc = pc_inc;
               decoded_in = data16;
            end else if (cyc == 3'd1) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pc;
               out_rsp_in.next_pc = pc_inc;
               decoded_in = idx_sum;
               crossed_in = (idx_sum & amseq_pkg::HIGH_BYTE_MASK) !=
                            (cross_base & amseq_pkg::HIGH_BYTE_MASK);
            end
            out_rsp_in.done_res = (cyc == 3'd2 && !crossed_in) || cyc == 3'd3;
         end
         amseq_pkg::MODE_INDX: begin
            if (cyc == 3'd0) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pc;
               out_rsp_in.next_pc = pc_inc;
               pointer_in = data16;
            end else if (cyc == 3'd1) begin
               pointer_in = (pointer_ff + {8'd0, s1_req_ff.index_x}) &
                            amseq_pkg::LOW_BYTE_MASK;
            end else if (cyc == 3'd2) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pointer_ff & amseq_pkg::LOW_BYTE_MASK;
               decoded_in = data16;
            end else if (cyc == 3'd3) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = (pointer_ff + 16'd1) & amseq_pkg::LOW_BYTE_MASK;
               decoded_in = hi_merge;
            end
            out_rsp_in.done_res = (cyc == 3'd4);
         end
         amseq_pkg::MODE_INDY: begin
            if (cyc == 3'd0) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pc;
               out_rsp_in.next_pc = pc_inc;
               pointer_in = data16;
            end else if (cyc == 3'd1) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pointer_ff;
               decoded_in = data16;
            end else if (cyc == 3'd2) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = (pointer_ff + 16'd1) & amseq_pkg::LOW_BYTE_MASK;
               decoded_in = hi_merge;
            end else if (cyc == 3'd3) begin
               decoded_in = idx_sum;
               crossed_in = (idx_sum & amseq_pkg::HIGH_BYTE_MASK) !=
                            (cross_base & amseq_pkg::HIGH_BYTE_MASK);
            end
            out_rsp_in.done_res = (cyc == 3'd3 && !crossed_in) || cyc == 3'd4;
         end
         amseq_pkg::MODE_IND: begin
            if (cyc == 3'd0) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pc;
               out_rsp_in.next_pc = pc_inc;
               pointer_in = data16;
            end else if (cyc == 3'd1) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pc;
               out_rsp_in.next_pc = pc_inc;
               pointer_in = (pointer_ff & amseq_pkg::LOW_BYTE_MASK) |
                            {s1_req_ff.read_data, 8'd0};
            end else if (cyc == 3'd2) begin
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pointer_ff;
               decoded_in = data16;
            end else if (cyc == 3'd3) begin
               // full carry into the high byte here, no page wrap
               out_rsp_in.read_enable = 1'b1;
               out_rsp_in.read_address = pointer_ff + 16'd1;
               decoded_in = hi_merge;
            end
            out_rsp_in.done_res = (cyc == 3'd4);
         end
         default: begin
            // accumulator, implied and unused codes
            out_rsp_in.done_res = 1'b1;
         end
      endcase
      out_rsp_in.effective_address = decoded_in;
   end

   always_comb begin
      s1_valid_in  = take_req ? 1'b1 : (s1_valid_ff && !advance);
      out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         decoded_ff   <= '0;
         pointer_ff   <= '0;
         crossed_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            decoded_ff <= decoded_in;
            pointer_ff <= pointer_in;
            crossed_ff <= crossed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !advance)
      else $error("held response overwritten");

   a_zp_high_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && cyc == 3'd0 && (mode == amseq_pkg::MODE_ZP ||
       mode == amseq_pkg::MODE_ZPX || mode == amseq_pkg::MODE_ZPY))
      |=> (decoded_ff[15:8] == 8'd0))
      else $error("zero-page operand left page zero");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(decoded_ff) && $stable(pointer_ff) && $stable(crossed_ff)))
      else $error("address state moved without a request");
`endif

endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for cpu_addressing_mode_sequencer, one request per cpu cycle
// depends on amseq_pkg and the sequencer rtl; predicts each response and compares in order
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] MODE_UNUSED = 4'd15;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 50;
   localparam int unsigned PHASE_REQUESTS = 306;

   typedef struct {
      amseq_pkg::req_type r;
      int unsigned        idle_pct;
      int unsigned        stall_pct;
   } cycle_request_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   amseq_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   amseq_pkg::rsp_type rsp_data;

   cycle_request_type  pending_requests[$];
   amseq_pkg::rsp_type expected_responses[$];

   // predicted sequencer state
   logic [15:0] operand_addr = '0;
   logic [15:0] pointer_addr = '0;
   logic        crossed = 1'b0;

   int unsigned stall_pct_now = 0;
   int unsigned mismatches = 0;
   int unsigned responses_checked = 0;
   int unsigned sequences_done = 0;
   int unsigned page_crossings = 0;
   int unsigned idle_cycles = 0;

   cpu_addressing_mode_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one cpu cycle of the addressing sequence, updating the predicted state
   task automatic predict_address_cycle(input amseq_pkg::req_type r,
                                        output amseq_pkg::rsp_type e);
      logic [7:0]  idx;
      logic [15:0] pc;
      logic [15:0] base;
      logic        pc_fetch;
      pc = r.program_counter;
      idx = (r.mode == amseq_pkg::MODE_ZPY || r.mode == amseq_pkg::MODE_ABSY)
            ? r.index_y : r.index_x;
      pc_fetch = 1'b0;
      e = '0;
      e.next_pc = pc;
      case (r.mode)
         amseq_pkg::MODE_IMM, amseq_pkg::MODE_REL: begin
            operand_addr = pc;
            e.next_pc = pc + 16'd1;
            e.done_res = 1'b1;
         end
         amseq_pkg::MODE_ZP: begin
            if (r.cycle_index == 3'd0) begin
               pc_fetch = 1'b1;
               operand_addr = {8'h00, r.read_data};
            end
            e.done_res = (r.cycle_index == 3'd1);
         end
         amseq_pkg::MODE_ZPX, amseq_pkg::MODE_ZPY: begin
            if (r.cycle_index == 3'd0) begin
               pc_fetch = 1'b1;
               operand_addr = {8'h00, r.read_data};
            end else if (r.cycle_index == 3'd1) begin
               operand_addr = (operand_addr + {8'h00, idx}) & amseq_pkg::LOW_BYTE_MASK;
            end
            e.done_res = (r.cycle_index == 3'd2);
         end
         amseq_pkg::MODE_ABS: begin
            if (r.cycle_index == 3'd0) begin
               pc_fetch = 1'b1;
               operand_addr = {8'h00, r.read_data};
            end else if (r.cycle_index == 3'd1) begin
               pc_fetch = 1'b1;
               operand_addr = {r.read_data, operand_addr[7:0]};
            end
            e.done_res = (r.cycle_index == 3'd2);
         end
         amseq_pkg::MODE_ABSX, amseq_pkg::MODE_ABSY: begin
            if (r.cycle_index == 3'd0) begin
               pc_fetch = 1'b1;
               operand_addr = {8'h00, r.read_data};
            end else if (r.cycle_index == 3'd1) begin
               pc_fetch = 1'b1;
               base = {r.read_data, operand_addr[7:0]};
               operand_addr = base + {8'h00, idx};
               crossed = (operand_addr & amseq_pkg::HIGH_BYTE_MASK) !=
                         (base & amseq_pkg::HIGH_BYTE_MASK);
               if (crossed) page_crossings++;
            end
            e.done_res = (r.cycle_index == 3'd2 && !crossed) || r.cycle_index == 3'd3;
         end
         amseq_pkg::MODE_INDX: begin
            if (r.cycle_index == 3'd0) begin
               pc_fetch = 1'b1;
               pointer_addr = {8'h00, r.read_data};
            end else if (r.cycle_index == 3'd1) begin
               pointer_addr = (pointer_addr + {8'h00, r.index_x}) & amseq_pkg::LOW_BYTE_MASK;
            end else if (r.cycle_index == 3'd2) begin
               e.read_enable = 1'b1;
               e.read_address = pointer_addr & amseq_pkg::LOW_BYTE_MASK;
               operand_addr = {8'h00, r.read_data};
            end else if (r.cycle_index == 3'd3) begin
               e.read_enable = 1'b1;
               e.read_address = (pointer_addr + 16'd1) & amseq_pkg::LOW_BYTE_MASK;
               operand_addr = {r.read_data, operand_addr[7:0]};
            end
            e.done_res = (r.cycle_index == 3'd4);
         end
         amseq_pkg::MODE_INDY: begin
            if (r.cycle_index == 3'd0) begin
               pc_fetch = 1'b1;
               pointer_addr = {8'h00, r.read_data};
            end else if (r.cycle_index == 3'd1) begin
               e.read_enable = 1'b1;
               e.read_address = pointer_addr;
               operand_addr = {8'h00, r.read_data};
            end else if (r.cycle_index == 3'd2) begin
               e.read_enable = 1'b1;
               e.read_address = (pointer_addr + 16'd1) & amseq_pkg::LOW_BYTE_MASK;
               operand_addr = {r.read_data, operand_addr[7:0]};
            end else if (r.cycle_index == 3'd3) begin
               base = operand_addr;
               operand_addr = base + {8'h00, r.index_y};
               crossed = (operand_addr & amseq_pkg::HIGH_BYTE_MASK) !=
                         (base & amseq_pkg::HIGH_BYTE_MASK);
               if (crossed) page_crossings++;
            end
            e.done_res = (r.cycle_index == 3'd3 && !crossed) || r.cycle_index == 3'd4;
         end
         amseq_pkg::MODE_IND: begin
            if (r.cycle_index == 3'd0) begin
               pc_fetch = 1'b1;
               pointer_addr = {8'h00, r.read_data};
            end else if (r.cycle_index == 3'd1) begin
               pc_fetch = 1'b1;
               pointer_addr = {r.read_data, pointer_addr[7:0]};
            end else if (r.cycle_index == 3'd2) begin
               e.read_enable = 1'b1;
               e.read_address = pointer_addr;
               operand_addr = {8'h00, r.read_data};
            end else if (r.cycle_index == 3'd3) begin
               // full 16-bit carry into the pointer's high byte
               e.read_enable = 1'b1;
               e.read_address = pointer_addr + 16'd1;
               operand_addr = {r.read_data, operand_addr[7:0]};
            end
            e.done_res = (r.cycle_index == 3'd4);
         end
         default: begin
            // accumulator, implied and the unused codes
            e.done_res = 1'b1;
         end
      endcase
      if (pc_fetch) begin
         e.read_enable = 1'b1;
         e.read_address = pc;
         e.next_pc = pc + 16'd1;
      end
      e.effective_address = operand_addr;
   endtask

   task automatic queue_request(input logic [3:0] mode, input logic [2:0] cyc,
                                input logic [15:0] pc, input logic [7:0] x,
                                input logic [7:0] y, input logic [7:0] data,
                                input int unsigned idle_pct, input int unsigned stall_pct);
      cycle_request_type c;
      c.r.mode = mode;
      c.r.cycle_index = cyc;
      c.r.program_counter = pc;
      c.r.index_x = x;
      c.r.index_y = y;
      c.r.read_data = data;
      c.idle_pct = idle_pct;
      c.stall_pct = stall_pct;
      pending_requests.push_back(c);
   endtask

   // bytes near the page edges turn up often so that wraps and crossings happen
   function automatic logic [7:0] edge_byte();
      case ($urandom_range(0, 7))
         0: edge_byte = 8'h00;
         1: edge_byte = 8'hFF;
         2: edge_byte = 8'hFE;
         3: edge_byte = 8'h01;
         default: edge_byte = 8'($urandom_range(0, 255));
      endcase
   endfunction

   // an addressing sequence of one mode with random content; returns its length
   task automatic queue_sequence(input int unsigned idle_pct, input int unsigned stall_pct,
                                 output int unsigned len);
      logic [3:0]  mode;
      logic [15:0] pc;
      logic [7:0]  x;
      logic [7:0]  y;
      mode = 4'($urandom_range(0, 12));
      pc = 16'($urandom_range(0, 65535));
      x = edge_byte();
      y = edge_byte();
      case (mode)
         amseq_pkg::MODE_ZP: len = 2;
         amseq_pkg::MODE_ZPX, amseq_pkg::MODE_ZPY, amseq_pkg::MODE_ABS: len = 3;
         amseq_pkg::MODE_ABSX, amseq_pkg::MODE_ABSY: len = 3 + $urandom_range(0, 1);
         amseq_pkg::MODE_INDY: len = 4 + $urandom_range(0, 1);
         amseq_pkg::MODE_INDX, amseq_pkg::MODE_IND: len = 5;
         default: len = 1;
      endcase
      for (int unsigned i = 0; i < len; i++) begin
         queue_request(mode, 3'(i), pc, x, y, edge_byte(), idle_pct, stall_pct);
         pc = pc + 16'd1;
      end
   endtask

   // driver: presents the head of the pending requests, holding it while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) pending_requests.pop_front();
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (pending_requests.size() != 0 &&
                      $urandom_range(0, 99) >= pending_requests[0].idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_requests[0].r;
            stall_pct_now <= pending_requests[0].stall_pct;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predicts on each accepted request, checks each accepted response
   always @(posedge clock) begin
      amseq_pkg::rsp_type e;
      logic               bad;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_address_cycle(req_data, e);
            if (e.done_res) sequences_done++;
            expected_responses.push_back(e);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: %p", rsp_data);
            end else begin
               e = expected_responses.pop_front();
               responses_checked++;
               bad = (rsp_data.read_enable !== e.read_enable) ||
                     (rsp_data.read_address !== e.read_address) ||
                     (rsp_data.next_pc !== e.next_pc) ||
                     (rsp_data.effective_address !== e.effective_address) ||
                     (rsp_data.done_res !== e.done_res);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rsp %0d exp/act rd %b/%b a %h/%h npc %h/%h ea %h/%h d %b/%b",
                              responses_checked, e.read_enable, rsp_data.read_enable,
                              e.read_address, rsp_data.read_address, e.next_pc,
                              rsp_data.next_pc, e.effective_address,
                              rsp_data.effective_address, e.done_res, rsp_data.done_res);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct_now);
      end
   end

   // watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no handshake for %0d cycles", idle_cycles);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned idle_by_phase[4];
      int unsigned stall_by_phase[4];
      int unsigned n;
      int unsigned len;
      idle_by_phase = '{0, 73, 0, 32};
      stall_by_phase = '{0, 0, 73, 32};

      // directed: simple modes, page-zero wraps, crossings, pointer carry
      queue_request(amseq_pkg::MODE_ACC, 3'd0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 0);
      queue_request(amseq_pkg::MODE_IMPL, 3'd7, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 0, 0);
      queue_request(amseq_pkg::MODE_IMM, 3'd0, 16'hFFFF, 8'h00, 8'h00, 8'h00, 0, 0);
      queue_request(MODE_UNUSED, 3'd0, 16'h1234, 8'h00, 8'h00, 8'hAA, 0, 0);
      queue_request(amseq_pkg::MODE_ZPX, 3'd0, 16'h1000, 8'h20, 8'h00, 8'hF0, 0, 0);
      queue_request(amseq_pkg::MODE_ZPX, 3'd1, 16'h1001, 8'h20, 8'h00, 8'h00, 0, 0);
      queue_request(amseq_pkg::MODE_ZPX, 3'd2, 16'h1001, 8'h20, 8'h00, 8'h00, 0, 0);
      queue_request(amseq_pkg::MODE_ABSY, 3'd0, 16'hFFFF, 8'h00, 8'h01, 8'hFF, 0, 0);
      queue_request(amseq_pkg::MODE_ABSY, 3'd1, 16'h0000, 8'h00, 8'h01, 8'h12, 0, 0);
      queue_request(amseq_pkg::MODE_ABSY, 3'd2, 16'h0001, 8'h00, 8'h01, 8'h00, 0, 0);
      queue_request(amseq_pkg::MODE_ABSY, 3'd3, 16'h0001, 8'h00, 8'h01, 8'h00, 0, 0);
      queue_request(amseq_pkg::MODE_INDX, 3'd0, 16'h2000, 8'h01, 8'h00, 8'hFE, 0, 0);
      queue_request(amseq_pkg::MODE_INDX, 3'd1, 16'h2001, 8'h01, 8'h00, 8'h00, 0, 0);
      queue_request(amseq_pkg::MODE_INDX, 3'd2, 16'h2001, 8'h01, 8'h00, 8'h34, 0, 0);
      queue_request(amseq_pkg::MODE_INDX, 3'd3, 16'h2001, 8'h01, 8'h00, 8'h12, 0, 0);
      queue_request(amseq_pkg::MODE_INDX, 3'd4, 16'h2001, 8'h01, 8'h00, 8'h00, 0, 0);
      queue_request(amseq_pkg::MODE_INDY, 3'd0, 16'h3000, 8'h00, 8'hFF, 8'hFF, 0, 0);
      queue_request(amseq_pkg::MODE_INDY, 3'd1, 16'h3001, 8'h00, 8'hFF, 8'hF0, 0, 0);
      queue_request(amseq_pkg::MODE_INDY, 3'd2, 16'h3001, 8'h00, 8'hFF, 8'h12, 0, 0);
      queue_request(amseq_pkg::MODE_INDY, 3'd3, 16'h3001, 8'h00, 8'hFF, 8'h00, 0, 0);
      queue_request(amseq_pkg::MODE_INDY, 3'd4, 16'h3001, 8'h00, 8'hFF, 8'h00, 0, 0);
      queue_request(amseq_pkg::MODE_IND, 3'd0, 16'h4000, 8'h00, 8'h00, 8'hFF, 0, 0);
      queue_request(amseq_pkg::MODE_IND, 3'd1, 16'h4001, 8'h00, 8'h00, 8'hFF, 0, 0);
      queue_request(amseq_pkg::MODE_IND, 3'd2, 16'h4002, 8'h00, 8'h00, 8'h78, 0, 0);
      queue_request(amseq_pkg::MODE_IND, 3'd3, 16'h4002, 8'h00, 8'h00, 8'h56, 0, 0);
      queue_request(amseq_pkg::MODE_IND, 3'd4, 16'h4002, 8'h00, 8'h00, 8'h00, 0, 0);

      // random: mostly whole sequences, some stray or out-of-range cycles
      for (int p = 0; p < 4; p++) begin
         n = 0;
         while (n < PHASE_REQUESTS) begin
            if ($urandom_range(0, 99) < 15) begin
               queue_request(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                             16'($urandom_range(0, 65535)), edge_byte(), edge_byte(),
                             edge_byte(), idle_by_phase[p], stall_by_phase[p]);
               len = 1;
            end else begin
               queue_sequence(idle_by_phase[p], stall_by_phase[p], len);
            end
            n += len;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || expected_responses.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d responses: %0d addressing sequences completed, %0d page crossings",
               responses_checked, sequences_done, page_crossings);
      $display("mismatches: %0d, responses still outstanding: %0d",
               mismatches, expected_responses.size());
      if (mismatches == 0 && expected_responses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
